@@ hw/rtl/inquire_reply_line_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Inquiry reply line decoder: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INQUIRE_REPLY_LINE_DECODER_DEFINES_SVH
`define INQUIRE_REPLY_LINE_DECODER_DEFINES_SVH

// same-cycle implication
`define IRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ird assertion failed");

// next-cycle implication
`define IRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ird assertion failed");

`endif

@@ hw/rtl/ird_pkg.sv @@
// ----------------------------------------------------------------------------
// Inquiry reply line decoder package
// Shared types, codes and helpers for the reply line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ird_pkg;

	localparam int COUNT_WIDTH   = 16;
	localparam int MAX_LEN_WIDTH = 16;
	localparam int CFG_DATA_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > MAX_LEN_WIDTH) ? COUNT_WIDTH : MAX_LEN_WIDTH;

	localparam logic [7:0] CH_PCT  = 8'h25;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_F    = 8'h46;

	localparam logic [7:0] HEX_BASE_DIGIT = 8'h30;
	localparam logic [7:0] HEX_BASE_UPPER = 8'h37;
	localparam logic [7:0] HEX_BASE_LOWER = 8'h57;

	localparam logic CFG_MAX_LEN       = 1'b0;
	localparam logic CFG_DATA_EXPECTED = 1'b1;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_EOL   = 2'd1,
		MODE_START = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CANCELED   = 3'd1,
		ST_UNEXPECTED = 3'd2,
		ST_TOO_MUCH   = 3'd3,
		ST_NESTED     = 3'd4
	} status_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] line_byte;
	} item_t;

	typedef struct packed {
		logic [MAX_LEN_WIDTH-1:0] max_len;
		logic                     data_expected;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] data_byte;
		status_t    status;
		logic       last;
	} result_t;

	// low nibble of the hex digit value, applied to any byte
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c <= CH_NINE)
			return c[3:0];
		return c[3:0] + 4'd9;
	endfunction

	// full 8-bit digit value of any byte; non-hex bytes carry past the nibble
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		if (c <= CH_NINE)
			return c - HEX_BASE_DIGIT;
		if (c <= CH_F)
			return c - HEX_BASE_UPPER;
		return c - HEX_BASE_LOWER;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ird_line_fsm.sv @@
// ----------------------------------------------------------------------------
// Inquiry reply line decoder: line state machine
// Holds inquiry and line state, classifies lines, percent-decodes D
// payloads and forms at most one result per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inquire_reply_line_decoder_defines.svh"

module ird_line_fsm import ird_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	typedef enum logic [2:0] {
		CL_NONE    = 3'd0,
		CL_COMMENT = 3'd1,
		CL_PREFIX  = 3'd2,
		CL_DATA    = 3'd3,
		CL_END     = 3'd4,
		CL_CANCEL  = 3'd5,
		CL_UNEXP   = 3'd6
	} line_class_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HI   = 2'd2
	} esc_t;

	logic                   active_q, active_d;
	logic [2:0]             column_q, column_d;
	line_class_t            class_q, class_d;
	logic [7:0]             first_q, first_d;
	esc_t                   esc_q, esc_d;
	logic [3:0]             hi_q, hi_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   over_q, over_d;

	logic       put_req;
	logic [7:0] put_val;
	logic       limit_hit;
	logic [7:0] b;

	assign b = item.line_byte;
	assign limit_hit = (cfg.max_len != '0) &&
		(CMP_WIDTH'(count_q) >= CMP_WIDTH'(cfg.max_len));

	always_comb begin
		active_d = active_q;
		column_d = column_q;
		class_d  = class_q;
		first_d  = first_q;
		esc_d    = esc_q;
		hi_d     = hi_q;
		count_d  = count_q;
		over_d   = over_q;
		put_req  = 1'b0;
		put_val  = b;
		res      = '0;

		case (item.mode)
			MODE_START: begin
				if (active_q) begin
					res.valid  = 1'b1;
					res.kind   = 1'b1;
					res.status = ST_NESTED;
				end else begin
					active_d = 1'b1;
					column_d = '0;
					class_d  = CL_NONE;
					first_d  = '0;
					esc_d    = ESC_NONE;
					hi_d     = '0;
					count_d  = '0;
					over_d   = 1'b0;
				end
			end
			MODE_EOL: begin
				if (active_q) begin
					column_d = '0;
					class_d  = CL_NONE;
					first_d  = '0;
					esc_d    = ESC_NONE;
					hi_d     = '0;
					res.kind = 1'b1;
					res.last = 1'b1;
					case (class_q)
						CL_PREFIX: begin
							res.valid  = 1'b1;
							res.status = (first_q == CH_E && column_q == 3'd3) ?
								ST_OK : ST_UNEXPECTED;
						end
						CL_DATA: begin
							res.valid  = over_q;
							res.status = ST_TOO_MUCH;
						end
						CL_END: begin
							res.valid  = 1'b1;
							res.status = ST_OK;
						end
						CL_CANCEL: begin
							res.valid  = 1'b1;
							res.status = ST_CANCELED;
						end
						CL_UNEXP: begin
							res.valid  = 1'b1;
							res.status = ST_UNEXPECTED;
						end
						default: ;
					endcase
					if (res.valid)
						active_d = 1'b0;
				end
			end
			MODE_BYTE: begin
				if (active_q) begin
					case (class_q)
						CL_NONE: begin
							if (b == CH_HASH) begin
								class_d = CL_COMMENT;
							end else if (b == CH_E || b == CH_C || b == CH_D) begin
								class_d = CL_PREFIX;
								first_d = b;
							end else begin
								class_d = CL_UNEXP;
							end
						end
						CL_PREFIX: begin
							if (first_q == CH_E) begin
								if (column_q == 3'd1)
									class_d = (b == CH_N) ? CL_PREFIX : CL_UNEXP;
								else if (column_q == 3'd2)
									class_d = (b == CH_D) ? CL_PREFIX : CL_UNEXP;
								else
									class_d = (b == CH_SP || b == CH_NUL) ? CL_END : CL_UNEXP;
							end else if (first_q == CH_C) begin
								if (column_q == 3'd1)
									class_d = (b == CH_A) ? CL_PREFIX : CL_UNEXP;
								else
									class_d = (b == CH_N) ? CL_CANCEL : CL_UNEXP;
							end else begin
								class_d = (b == CH_SP && cfg.data_expected) ? CL_DATA : CL_UNEXP;
							end
						end
						CL_DATA: begin
							case (esc_q)
								ESC_NONE: begin
									if (b == CH_PCT)
										esc_d = ESC_PCT;
									else
										put_req = 1'b1;
								end
								ESC_PCT: begin
									hi_d  = hex_nibble(b);
									esc_d = ESC_HI;
								end
								default: begin
									esc_d   = ESC_NONE;
									put_req = 1'b1;
									put_val = {hi_q, 4'h0} + hex_value(b);
								end
							endcase
						end
						default: ;
					endcase
					column_d = (column_q != 3'd7) ? column_q + 3'd1 : column_q;
				end
			end
			default: ;
		endcase

		if (put_req && !over_q) begin
			if (limit_hit) begin
				over_d = 1'b1;
			end else begin
				if (count_q != '1)
					count_d = count_q + 1'b1;
				res.valid     = 1'b1;
				res.kind      = 1'b0;
				res.data_byte = put_val;
				res.status    = ST_OK;
				res.last      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			column_q <= '0;
			class_q  <= CL_NONE;
			first_q  <= '0;
			esc_q    <= ESC_NONE;
			hi_q     <= '0;
			count_q  <= '0;
			over_q   <= 1'b0;
		end else if (step) begin
			active_q <= active_d;
			column_q <= column_d;
			class_q  <= class_d;
			first_q  <= first_d;
			esc_q    <= esc_d;
			hi_q     <= hi_d;
			count_q  <= count_d;
			over_q   <= over_d;
		end
	end

	`IRD_ASSERT_NOW(a_nested_only_active, clk, arst_n,
		res.valid && res.kind && res.status == ST_NESTED, active_q && !res.last)
	`IRD_ASSERT_NOW(a_data_only_in_d_line, clk, arst_n,
		res.valid && !res.kind, class_q == CL_DATA && !over_q && active_q)
	`IRD_ASSERT_NEXT(a_last_closes, clk, arst_n,
		step && res.valid && res.last, !active_q && class_q == CL_NONE)
	`IRD_ASSERT_NEXT(a_start_opens, clk, arst_n,
		step && item.mode == MODE_START && !active_q, active_q && count_q == '0 && !over_q)

endmodule

`default_nettype wire

@@ hw/rtl/inquire_reply_line_decoder.sv @@
// ----------------------------------------------------------------------------
// Inquiry reply line decoder
// Decodes reply lines of an inquiry: status lines and percent-encoded data.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready, mode and line_byte per beat (start,
//                 line byte or end of line).
//   out channel : out_valid/out_ready, kind, data_byte, status, last. A beat
//                 is a decoded data byte or a status; last marks the status
//                 that closes the inquiry.
//   cfg channel : cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
//                 write only while no beat is in flight.
// Path: each input beat is registered in the input register, then its result
//   in the result register; it waits while the result register is held.
// Throughput: one input beat per cycle while the receiver takes results.
// Reset: no inquiry open, max_len 0 (unlimited), data_expected 1, no beats
//   held on either side.
// Receiver stall: the result register holds; the input register fills and
//   in_ready drops only when both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module inquire_reply_line_decoder import ird_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [7:0]                line_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      kind,
	output logic [7:0]                data_byte,
	output logic [2:0]                status,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	logic    valid_s1;
	item_t   item_s1;
	result_t res;
	result_t out_q;
	cfg_t    cfg_q;
	logic    step;

	assign step      = valid_s1 && (!out_q.valid || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_ready && in_valid) begin
			item_s1 <= '{mode: mode_t'(mode), line_byte: line_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len       <= '0;
			cfg_q.data_expected <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_LEN:       cfg_q.max_len <= MAX_LEN_WIDTH'(cfg_data);
				CFG_DATA_EXPECTED: cfg_q.data_expected <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ird_line_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (step) begin
			out_q <= res;
		end else if (out_ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid = out_q.valid;
	assign kind      = out_q.kind;
	assign data_byte = out_q.data_byte;
	assign status    = out_q.status;
	assign last      = out_q.last;

endmodule

`default_nettype wire

@@ test/inquire_reply_line_decoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Inquiry reply line decoder testbench
// Feeds inquiries (start beats, reply text lines, end-of-line beats) into the
// decoder and checks each result beat against a scoreboard. The scoreboard
// tracks the line parser, the percent decoder and the data limit. Stimulus is
// a short directed sequence, then random inquiries under several register
// settings and handshake idling mixes.
// ----------------------------------------------------------------------------

module inquire_reply_line_decoder_test;
	import ird_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 175;
	localparam int NUM_PHASES = 8;
	localparam int HOLD_CYCLES = 400;

	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_UPPER_F = "F";
	localparam logic [7:0] CH_LOWER_A = "a";

	typedef enum logic [2:0] {
		LC_NONE, LC_COMMENT, LC_PREFIX, LC_DATA, LC_END, LC_CANCEL, LC_UNEXP
	} line_class_t;

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_HIGH} escape_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		status_t    status;
		logic       last;
	} beat_t;

	class reply_scoreboard;
		logic [15:0]            max_len = '0;
		logic                   data_expected = 1'b1;
		logic                   active = 1'b0;
		logic [2:0]             column = '0;
		line_class_t            line_class = LC_NONE;
		logic [7:0]             lead_char = '0;
		escape_t                escape_phase = ESC_NONE;
		logic [3:0]             high_nibble = '0;
		logic [COUNT_WIDTH-1:0] byte_count = '0;
		logic                   over_limit = 1'b0;
		beat_t                  expected_beats[$];
		int                     errors = 0;

		function int pending();
			return expected_beats.size();
		endfunction

		function void write_reg(logic idx, logic [15:0] value);
			if (idx == CFG_MAX_LEN)
				max_len = value;
			else
				data_expected = value[0];
		endfunction

		function void push_beat(logic k, logic [7:0] d, status_t st, logic l);
			beat_t b;
			b.kind = k;
			b.data_byte = d;
			b.status = st;
			b.last = l;
			expected_beats.push_back(b);
		endfunction

		function void clear_line();
			column = '0;
			line_class = LC_NONE;
			lead_char = '0;
			escape_phase = ESC_NONE;
			high_nibble = '0;
		endfunction

		// any byte is taken as a digit; only the low 8 bits of the sum matter
		function logic [7:0] digit_value(logic [7:0] c);
			if (c <= CH_NINE)
				return c - CH_ZERO;
			if (c <= CH_UPPER_F)
				return c - (CH_A - 8'd10);
			return c - (CH_LOWER_A - 8'd10);
		endfunction

		function void pass_byte(logic [7:0] v);
			if (over_limit)
				return;
			if (max_len != 0 && byte_count >= max_len) begin
				over_limit = 1'b1;
				return;
			end
			if (byte_count != '1)
				byte_count++;
			push_beat(1'b0, v, ST_OK, 1'b0);
		endfunction

		function void data_char(logic [7:0] b);
			case (escape_phase)
			ESC_NONE: begin
				if (b == CH_PCT)
					escape_phase = ESC_PCT;
				else
					pass_byte(b);
			end
			ESC_PCT: begin
				high_nibble = 4'(digit_value(b));
				escape_phase = ESC_HIGH;
			end
			default: begin
				escape_phase = ESC_NONE;
				pass_byte({high_nibble, 4'h0} + digit_value(b));
			end
			endcase
		endfunction

		function void prefix_char(logic [2:0] col, logic [7:0] b);
			if (lead_char == CH_E) begin
				if (col == 3'd1)
					line_class = (b == CH_N) ? LC_PREFIX : LC_UNEXP;
				else if (col == 3'd2)
					line_class = (b == CH_D) ? LC_PREFIX : LC_UNEXP;
				else
					line_class = (b == CH_SP || b == CH_NUL) ? LC_END : LC_UNEXP;
			end else if (lead_char == CH_C) begin
				if (col == 3'd1)
					line_class = (b == CH_A) ? LC_PREFIX : LC_UNEXP;
				else
					line_class = (b == CH_N) ? LC_CANCEL : LC_UNEXP;
			end else begin
				line_class = (b == CH_SP && data_expected) ? LC_DATA : LC_UNEXP;
			end
		endfunction

		function void text_byte(logic [7:0] b);
			logic [2:0] col;
			col = column;
			case (line_class)
			LC_NONE: begin
				if (b == CH_HASH) begin
					line_class = LC_COMMENT;
				end else if (b == CH_E || b == CH_C || b == CH_D) begin
					line_class = LC_PREFIX;
					lead_char = b;
				end else begin
					line_class = LC_UNEXP;
				end
			end
			LC_PREFIX: prefix_char(col, b);
			LC_DATA: data_char(b);
			default: ;
			endcase
			column = (col < 3'd7) ? col + 3'd1 : 3'd7;
		endfunction

		function void line_end();
			logic    done;
			status_t st;
			done = 1'b1;
			st = ST_OK;
			case (line_class)
			LC_PREFIX: st = (lead_char == CH_E && column == 3'd3) ? ST_OK : ST_UNEXPECTED;
			LC_DATA: begin
				if (over_limit)
					st = ST_TOO_MUCH;
				else
					done = 1'b0;
			end
			LC_END: st = ST_OK;
			LC_CANCEL: st = ST_CANCELED;
			LC_UNEXP: st = ST_UNEXPECTED;
			default: done = 1'b0;
			endcase
			clear_line();
			if (done) begin
				active = 1'b0;
				push_beat(1'b1, 8'h00, st, 1'b1);
			end
		endfunction

		function void take_item(mode_t m, logic [7:0] b);
			case (m)
			MODE_START: begin
				if (active) begin
					push_beat(1'b1, 8'h00, ST_NESTED, 1'b0);
				end else begin
					active = 1'b1;
					clear_line();
					byte_count = '0;
					over_limit = 1'b0;
				end
			end
			MODE_EOL: if (active) line_end();
			MODE_BYTE: if (active) text_byte(b);
			default: ;
			endcase
		endfunction

		function void check_beat(logic k, logic [7:0] d, logic [2:0] s, logic l);
			beat_t e;
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: kind %0d data %0d status %0d last %0d",
					k, d, s, l);
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, k);
				errors++;
			end
			if (d !== e.data_byte) begin
				$error("data_byte: expected %0d, got %0d", e.data_byte, d);
				errors++;
			end
			if (s !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, s);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                mode = MODE_BYTE;
	logic [7:0]                line_byte = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      kind;
	logic [7:0]                data_byte;
	logic [2:0]                status;
	logic                      last;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_index = CFG_MAX_LEN;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	reply_scoreboard sb = new();

	int    in_idle_pct = 0;
	int    out_stall_pct = 0;
	int    hold_req = 0;
	int    hold_left = 0;
	int    quiet_cycles = 0;
	int    items_done = 0;
	string hex_chars = "0123456789ABCDEFabcdef";

	int          max_len_tab[NUM_PHASES] = '{0, 1, 65535, 3, 8, 0, 2, 12};
	logic        data_exp_tab[NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1};

	inquire_reply_line_decoder i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_beat(kind, data_byte, status, last);
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void set_idling(input int p);
		case (p % 4)
		0: begin in_idle_pct = 0; out_stall_pct = 0; end
		1: begin in_idle_pct = 83; out_stall_pct = 0; end
		2: begin in_idle_pct = 0; out_stall_pct = 83; end
		default: begin in_idle_pct = 31; out_stall_pct = 31; end
		endcase
	endfunction

	function automatic logic [7:0] any_digit();
		if ($urandom_range(3) != 0)
			return hex_chars[$urandom_range(21)];
		return 8'($urandom_range(255));
	endfunction

	// valid is only lowered for a gap, so back-to-back beats never toggle it
	task automatic send_item(input mode_t m, input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		line_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_START || (sb.active && m != MODE_RSVD))
			items_done++;
		sb.take_item(m, b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(MODE_BYTE, s[i]);
	endtask

	task automatic send_eol();
		send_item(MODE_EOL, 8'($urandom_range(255)));
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] limit_val, input logic de);
		logic [15:0] de_word;
		de_word = {15'($urandom), de};
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= limit_val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(CFG_MAX_LEN, limit_val);
		cfg_index <= CFG_DATA_EXPECTED;
		cfg_data <= de_word;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(CFG_DATA_EXPECTED, de_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_data_line();
		send_text("D ");
		repeat ($urandom_range(0, 10)) begin
			if ($urandom_range(3) == 0) begin
				send_item(MODE_BYTE, CH_PCT);
				send_item(MODE_BYTE, any_digit());
				send_item(MODE_BYTE, any_digit());
			end else begin
				send_item(MODE_BYTE, 8'($urandom_range(255)));
			end
		end
		// dangling escape at line end
		if ($urandom_range(5) == 0) begin
			send_item(MODE_BYTE, CH_PCT);
			if ($urandom_range(1) != 0)
				send_item(MODE_BYTE, any_digit());
		end
		send_eol();
	endtask

	// END / CAN / D prefixes, intact or broken, and plain junk lines
	task automatic send_status_line();
		string      tmpl;
		int         n;
		logic [7:0] b;
		case ($urandom_range(3))
		0: tmpl = "END ";
		1: tmpl = "CAN ";
		2: tmpl = "D ";
		default: tmpl = "";
		endcase
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			if (i < tmpl.len() && $urandom_range(3) != 0)
				b = tmpl[i];
			else if ($urandom_range(3) == 0)
				b = CH_NUL;
			else
				b = 8'($urandom_range(255));
			send_item(MODE_BYTE, b);
		end
		send_eol();
	endtask

	task automatic random_inquiry();
		if ($urandom_range(15) != 0)
			send_item(MODE_START, 8'($urandom_range(255)));
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: send_data_line();
			6: begin
				send_item(MODE_BYTE, CH_HASH);
				repeat ($urandom_range(0, 9))
					send_item(MODE_BYTE, 8'($urandom_range(255)));
				send_eol();
			end
			7: send_eol();
			8: send_item(MODE_START, 8'($urandom_range(255)));
			default: send_item(mode_t'($urandom_range(3)), 8'($urandom_range(255)));
			endcase
		end
		if ($urandom_range(7) != 0)
			send_status_line();
	endtask

	initial begin
		set_idling(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no inquiry open: ignored beats, then the reserved mode
		send_item(MODE_BYTE, 8'hFF);
		send_item(MODE_EOL, 8'h00);
		send_item(MODE_RSVD, 8'h5A);
		send_item(MODE_START, 8'h00);
		send_item(MODE_START, 8'hFF);
		send_item(MODE_EOL, 8'h00);
		send_item(MODE_BYTE, CH_HASH);
		send_eol();
		send_text("D %41");
		send_item(MODE_BYTE, 8'hFF);
		send_text("%z");
		send_eol();
		send_item(MODE_BYTE, CH_D);
		send_eol();
		send_item(MODE_START, 8'h00);
		send_text("END");
		send_item(MODE_BYTE, CH_NUL);
		send_eol();
		wait_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_idling(p);
			set_regs(16'(max_len_tab[p]), data_exp_tab[p]);
			if (p == 0)
				hold_req = HOLD_CYCLES;
			while (items_done < (p + 1) * PHASE_ITEMS)
				random_inquiry();
			wait_results();
		end
		repeat (16) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
